// ===== rtl/pbms_pkg.sv =====
// Shared types, codes, reset values and arithmetic helpers of the planar body motion step.
package pbms_pkg;

    // Item kinds carried on the input tuser
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_LAND  = 2'd1;
    localparam logic [1:0] FUNC_LEAVE = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_GRAVITY_X      = 3'd0;
    localparam logic [2:0] REG_GRAVITY_Y      = 3'd1;
    localparam logic [2:0] REG_BODY_MASS      = 3'd2;
    localparam logic [2:0] REG_SPEED_LIMIT_X  = 3'd3;
    localparam logic [2:0] REG_SPEED_LIMIT_Y  = 3'd4;
    localparam logic [2:0] REG_FRICTION_FORCE = 3'd5;
    localparam logic [2:0] REG_GRAVITY_ENABLE = 3'd6;
    localparam logic [2:0] REG_TIME_STEP      = 3'd7;

    // Configuration reset values
    localparam logic [31:0] RST_GRAVITY_X      = 32'd0;
    localparam logic [31:0] RST_GRAVITY_Y      = 32'd39321600;
    localparam logic [30:0] RST_BODY_MASS      = 31'd65536;
    localparam logic [30:0] RST_SPEED_LIMIT_X  = 31'd19660800;
    localparam logic [30:0] RST_SPEED_LIMIT_Y  = 31'd19660800;
    localparam logic [30:0] RST_FRICTION_FORCE = 31'd32768000;
    localparam logic        RST_GRAVITY_ENABLE = 1'b0;
    localparam logic [15:0] RST_TIME_STEP      = 16'd1092;

    typedef struct packed {
        logic signed [31:0] gravity_x;
        logic signed [31:0] gravity_y;
        logic [30:0]        body_mass;
        logic [30:0]        speed_limit_x;
        logic [30:0]        speed_limit_y;
        logic [30:0]        friction_force;
        logic               gravity_enable;
        logic [15:0]        time_step;
    } cfg_t;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_LAND,
        OP_LEAVE,
        OP_MUL_FX,
        OP_MUL_FY,
        OP_MUL_FF,
        OP_MUL_AX,
        OP_MUL_AY,
        OP_MUL_DD,
        OP_MUL_DX,
        OP_MUL_DY,
        OP_MUL_PX,
        OP_MUL_PY,
        OP_DIV_M,
        OP_DIV_S,
        OP_SQRT,
        OP_UPD_VX,
        OP_UPD_VY,
        OP_SET_D,
        OP_SUM_A,
        OP_SUM_B,
        OP_KILL,
        OP_FRIC_X,
        OP_FRIC_Y,
        OP_POS_X,
        OP_POS_Y
    } op_t;

    typedef struct packed {
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       div_done;
        logic       sqrt_done;
        logic       fric_go;
        logic       kill;
    } status_t;

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        abs33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        abs32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Limit a wide velocity to +/- lim
    function automatic logic signed [31:0] clamp_vel(input logic signed [51:0] v,
                                                     input logic [30:0] lim);
        logic signed [51:0] l;
        l = signed'({21'b0, lim});
        if (v > l)
            clamp_vel = l[31:0];
        else if (v < -l)
            clamp_vel = 32'(-l);
        else
            clamp_vel = v[31:0];
    endfunction

    // Saturate to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sh0_7FFF_FFFF;
        lo = 34'sh3_8000_0000;
        if (v > hi)
            sat32 = 32'sh7FFF_FFFF;
        else if (v < lo)
            sat32 = 32'sh8000_0000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

// ===== rtl/pbms_div.sv =====
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module pbms_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [63:0] quotient,
    output logic        done
);

    logic [31:0] rem_reg,  rem_next;
    logic [63:0] quo_reg,  quo_next;
    logic [31:0] dvs_reg,  dvs_next;
    logic [5:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // Shift one dividend bit into the partial remainder and try a subtract
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]};
        if (start)
        begin
            rem_next  = 32'd0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 6'd63;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 32'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/pbms_sqrt.sv =====
// Digit-by-digit integer square root of a 64-bit value, one result bit per cycle.
module pbms_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic [31:0] root,
    output logic        done
);

    logic [63:0] rem_reg,  rem_next;
    logic [63:0] res_reg,  res_next;
    logic [4:0]  k_reg,    k_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] bit_val;
    logic [63:0] trial;

    assign bit_val = 64'd1 << {k_reg, 1'b0};
    assign trial   = res_reg + bit_val;

    // Settle one root bit per cycle from the top down
    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = radicand;
            res_next  = 64'd0;
            k_next    = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_val;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            k_next = k_reg - 5'd1;
            if (k_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign root = res_reg[31:0];
    assign done = done_reg;

endmodule

// ===== rtl/pbms_dp.sv =====
// Datapath: item registers, body state, shared multiplier, divider and square root.
module pbms_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pbms_pkg::cfg_t         cfg,
    input  pbms_pkg::cmd_t         cmd,
    output pbms_pkg::status_t      status,
    input  logic [1:0]             func,
    input  logic signed [31:0]     force_x,
    input  logic signed [31:0]     force_y,
    input  logic signed [31:0]     pos_in_x,
    input  logic signed [31:0]     pos_in_y,
    output logic signed [31:0]     pos_out_x,
    output logic signed [31:0]     pos_out_y,
    output logic signed [31:0]     vel_out_x,
    output logic signed [31:0]     vel_out_y,
    output logic                   grounded
);
    import pbms_pkg::*;

    logic [1:0]         func_reg;
    logic signed [32:0] fx_reg, fy_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [63:0]        prod_reg;
    logic               neg_reg;
    logic [46:0]        d_reg;
    logic [63:0]        sum_reg;
    logic signed [31:0] vel_x_reg, vel_x_next;
    logic signed [31:0] vel_y_reg, vel_y_next;
    logic               ground_reg, ground_next;
    logic signed [31:0] out_px_reg, out_py_reg, out_vx_reg, out_vy_reg;
    logic               out_gnd_reg;

    logic               grav_on;
    logic [32:0]        mul_a;
    logic [31:0]        mul_b;
    logic [64:0]        mul_p;
    logic [31:0]        mass_eff;
    logic               div_start;
    logic [31:0]        div_divisor;
    logic [63:0]        div_q;
    logic               div_done;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic signed [51:0] qv;
    logic signed [33:0] delta;
    logic signed [31:0] vsel;
    logic signed [31:0] psel;

    assign grav_on  = cfg.gravity_enable && !ground_reg;
    assign mass_eff = (cfg.body_mass == 31'd0) ? 32'd1 : {1'b0, cfg.body_mass};

    // Select multiplier operands
    always_comb
    begin
        mul_a = 33'd0;
        mul_b = 32'd0;
        case (cmd.op)
            OP_MUL_FX:
            begin
                mul_a = abs33(fx_reg);
                mul_b = {16'd0, cfg.time_step};
            end
            OP_MUL_FY:
            begin
                mul_a = abs33(fy_reg);
                mul_b = {16'd0, cfg.time_step};
            end
            OP_MUL_FF:
            begin
                mul_a = {2'b0, cfg.friction_force};
                mul_b = {16'd0, cfg.time_step};
            end
            OP_MUL_AX:
            begin
                mul_a = {1'b0, abs32(vel_x_reg)};
                mul_b = abs32(vel_x_reg);
            end
            OP_MUL_AY:
            begin
                mul_a = {1'b0, abs32(vel_y_reg)};
                mul_b = abs32(vel_y_reg);
            end
            OP_MUL_DD:
            begin
                mul_a = {1'b0, d_reg[31:0]};
                mul_b = d_reg[31:0];
            end
            OP_MUL_DX:
            begin
                mul_a = {1'b0, d_reg[31:0]};
                mul_b = abs32(vel_x_reg);
            end
            OP_MUL_DY:
            begin
                mul_a = {1'b0, d_reg[31:0]};
                mul_b = abs32(vel_y_reg);
            end
            OP_MUL_PX:
            begin
                mul_a = {1'b0, abs32(vel_x_reg)};
                mul_b = {16'd0, cfg.time_step};
            end
            OP_MUL_PY:
            begin
                mul_a = {1'b0, abs32(vel_y_reg)};
                mul_b = {16'd0, cfg.time_step};
            end
            default:
            begin
                mul_a = 33'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {33'd0, mul_b};

    // Divider and square root units
    assign div_start   = (cmd.op == OP_DIV_M) || (cmd.op == OP_DIV_S);
    assign div_divisor = (cmd.op == OP_DIV_S) ? sqrt_root : mass_eff;

    pbms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    pbms_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_SQRT),
        .radicand (sum_reg),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    // Signed quotient and position step
    always_comb
    begin
        qv    = signed'({4'b0, div_q[47:0]});
        if (neg_reg)
            qv = -qv;
        delta = signed'({3'b0, prod_reg[46:16]});
        if (neg_reg)
            delta = -delta;
        vsel  = (cmd.op == OP_UPD_VY) ? vel_y_reg : vel_x_reg;
        psel  = (cmd.op == OP_POS_Y) ? py_reg : px_reg;
    end

    // Update body state
    always_comb
    begin
        vel_x_next  = vel_x_reg;
        vel_y_next  = vel_y_reg;
        ground_next = ground_reg;
        case (cmd.op)
            OP_LAND:
            begin
                ground_next = 1'b1;
                vel_y_next  = 32'sd0;
            end
            OP_LEAVE:  ground_next = 1'b0;
            OP_UPD_VX: vel_x_next = clamp_vel({{20{vsel[31]}}, vsel} + qv,
                                              cfg.speed_limit_x);
            OP_UPD_VY: vel_y_next = clamp_vel({{20{vsel[31]}}, vsel} + qv,
                                              cfg.speed_limit_y);
            OP_KILL:
            begin
                vel_x_next = 32'sd0;
                vel_y_next = 32'sd0;
            end
            OP_FRIC_X: vel_x_next = vel_x_reg[31] ? vel_x_reg + signed'(div_q[31:0])
                                                  : vel_x_reg - signed'(div_q[31:0]);
            OP_FRIC_Y: vel_y_next = vel_y_reg[31] ? vel_y_reg + signed'(div_q[31:0])
                                                  : vel_y_reg - signed'(div_q[31:0]);
            default:
            begin
                vel_x_next  = vel_x_reg;
                vel_y_next  = vel_y_reg;
                ground_next = ground_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_x_reg  <= 32'sd0;
            vel_y_reg  <= 32'sd0;
            ground_reg <= 1'b0;
        end
        else
        begin
            vel_x_reg  <= vel_x_next;
            vel_y_reg  <= vel_y_next;
            ground_reg <= ground_next;
        end
    end

    // Capture the item and hold working values
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                func_reg <= func;
                px_reg   <= pos_in_x;
                py_reg   <= pos_in_y;
                fx_reg   <= 33'(force_x) + (grav_on ? 33'(cfg.gravity_x) : 33'sd0);
                fy_reg   <= 33'(force_y) + (grav_on ? 33'(cfg.gravity_y) : 33'sd0);
            end
            OP_MUL_FX, OP_MUL_FY, OP_MUL_FF, OP_MUL_AX, OP_MUL_AY, OP_MUL_DD,
            OP_MUL_DX, OP_MUL_DY, OP_MUL_PX, OP_MUL_PY:
            begin
                prod_reg <= mul_p[63:0];
                case (cmd.op)
                    OP_MUL_FX:            neg_reg <= fx_reg[32];
                    OP_MUL_FY:            neg_reg <= fy_reg[32];
                    OP_MUL_DX, OP_MUL_PX: neg_reg <= vel_x_reg[31];
                    OP_MUL_DY, OP_MUL_PY: neg_reg <= vel_y_reg[31];
                    default:              neg_reg <= 1'b0;
                endcase
            end
            OP_SET_D: d_reg   <= div_q[46:0];
            OP_SUM_A: sum_reg <= prod_reg;
            OP_SUM_B: sum_reg <= sum_reg + prod_reg;
            OP_POS_X: px_reg  <= sat32({{2{psel[31]}}, psel} + delta);
            OP_POS_Y: py_reg  <= sat32({{2{psel[31]}}, psel} + delta);
            default:  func_reg <= func_reg;
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_px_reg  <= px_reg;
            out_py_reg  <= py_reg;
            out_vx_reg  <= vel_x_reg;
            out_vy_reg  <= vel_y_reg;
            out_gnd_reg <= ground_reg;
        end
    end

    assign pos_out_x = out_px_reg;
    assign pos_out_y = out_py_reg;
    assign vel_out_x = out_vx_reg;
    assign vel_out_y = out_vy_reg;
    assign grounded  = out_gnd_reg;

    // Status back to the controller
    assign status.func      = func_reg;
    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;
    assign status.fric_go   = (fx_reg == 33'sd0) && (fy_reg == 33'sd0)
                              && ((vel_x_reg != 32'sd0) || (vel_y_reg != 32'sd0));
    assign status.kill      = (d_reg[46:32] != 15'd0) || (sum_reg < prod_reg);

endmodule

// ===== rtl/pbms_ctrl.sv =====
// Controller: sequences datapath operations for one item and owns the handshakes.
module pbms_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  pbms_pkg::status_t status,
    output pbms_pkg::cmd_t    cmd
);
    import pbms_pkg::*;

    typedef enum logic [26:0] {
        ST_IDLE = 27'b1 << 0,
        ST_DISP = 27'b1 << 1,
        ST_DXS  = 27'b1 << 2,
        ST_DXW  = 27'b1 << 3,
        ST_MY   = 27'b1 << 4,
        ST_DYS  = 27'b1 << 5,
        ST_DYW  = 27'b1 << 6,
        ST_CHK  = 27'b1 << 7,
        ST_DDS  = 27'b1 << 8,
        ST_DDW  = 27'b1 << 9,
        ST_AX   = 27'b1 << 10,
        ST_SA   = 27'b1 << 11,
        ST_AY   = 27'b1 << 12,
        ST_SB   = 27'b1 << 13,
        ST_DD   = 27'b1 << 14,
        ST_CMP  = 27'b1 << 15,
        ST_SQW  = 27'b1 << 16,
        ST_FXS  = 27'b1 << 17,
        ST_FXW  = 27'b1 << 18,
        ST_FYM  = 27'b1 << 19,
        ST_FYS  = 27'b1 << 20,
        ST_FYW  = 27'b1 << 21,
        ST_PXM  = 27'b1 << 22,
        ST_PX   = 27'b1 << 23,
        ST_PYM  = 27'b1 << 24,
        ST_PY   = 27'b1 << 25,
        ST_FIN  = 27'b1 << 26
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Step through the item's operations
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NOP;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                unique case (status.func)
                    FUNC_TICK:
                    begin
                        cmd.op     = OP_MUL_FX;
                        state_next = ST_DXS;
                    end
                    FUNC_LAND:
                    begin
                        cmd.op     = OP_LAND;
                        state_next = ST_FIN;
                    end
                    FUNC_LEAVE:
                    begin
                        cmd.op     = OP_LEAVE;
                        state_next = ST_FIN;
                    end
                    default: state_next = ST_FIN;
                endcase
            end
            ST_DXS:
            begin
                cmd.op     = OP_DIV_M;
                state_next = ST_DXW;
            end
            ST_DXW:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_UPD_VX;
                    state_next = ST_MY;
                end
            end
            ST_MY:
            begin
                cmd.op     = OP_MUL_FY;
                state_next = ST_DYS;
            end
            ST_DYS:
            begin
                cmd.op     = OP_DIV_M;
                state_next = ST_DYW;
            end
            ST_DYW:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_UPD_VY;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (status.fric_go)
                begin
                    cmd.op     = OP_MUL_FF;
                    state_next = ST_DDS;
                end
                else
                begin
                    cmd.op     = OP_MUL_PX;
                    state_next = ST_PX;
                end
            end
            ST_DDS:
            begin
                cmd.op     = OP_DIV_M;
                state_next = ST_DDW;
            end
            ST_DDW:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_SET_D;
                    state_next = ST_AX;
                end
            end
            ST_AX:
            begin
                cmd.op     = OP_MUL_AX;
                state_next = ST_SA;
            end
            ST_SA:
            begin
                cmd.op     = OP_SUM_A;
                state_next = ST_AY;
            end
            ST_AY:
            begin
                cmd.op     = OP_MUL_AY;
                state_next = ST_SB;
            end
            ST_SB:
            begin
                cmd.op     = OP_SUM_B;
                state_next = ST_DD;
            end
            ST_DD:
            begin
                cmd.op     = OP_MUL_DD;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.kill)
                begin
                    cmd.op     = OP_KILL;
                    state_next = ST_PXM;
                end
                else
                begin
                    cmd.op     = OP_SQRT;
                    state_next = ST_SQW;
                end
            end
            ST_SQW:
            begin
                if (status.sqrt_done)
                begin
                    cmd.op     = OP_MUL_DX;
                    state_next = ST_FXS;
                end
            end
            ST_FXS:
            begin
                cmd.op     = OP_DIV_S;
                state_next = ST_FXW;
            end
            ST_FXW:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_FRIC_X;
                    state_next = ST_FYM;
                end
            end
            ST_FYM:
            begin
                cmd.op     = OP_MUL_DY;
                state_next = ST_FYS;
            end
            ST_FYS:
            begin
                cmd.op     = OP_DIV_S;
                state_next = ST_FYW;
            end
            ST_FYW:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_FRIC_Y;
                    state_next = ST_PXM;
                end
            end
            ST_PXM:
            begin
                cmd.op     = OP_MUL_PX;
                state_next = ST_PX;
            end
            ST_PX:
            begin
                cmd.op     = OP_POS_X;
                state_next = ST_PYM;
            end
            ST_PYM:
            begin
                cmd.op     = OP_MUL_PY;
                state_next = ST_PY;
            end
            ST_PY:
            begin
                cmd.op     = OP_POS_Y;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold the result item until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/planar_body_motion_step.sv =====
// Sequence: land, leave and unused items pass only the dispatch and finish states; a tick
// without friction two divides, a tick with friction up to five divides and a square root.
// Flow: one item at a time. A new item is taken while the previous result still waits in
// the output register.
// Reset: asynchronous active-low; clears velocity, ground flag, controller and the
// configuration registers to their defaults.
module planar_body_motion_step (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // force_x, force_y, pos_in_x, pos_in_y
    input  logic [1:0]   s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,  // pos_out_x, pos_out_y, vel_out_x, vel_out_y, grounded
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import pbms_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    cmd_t    cmd;
    status_t status;

    logic signed [31:0] pos_out_x, pos_out_y, vel_out_x, vel_out_y;
    logic               grounded;

    // Write configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRAVITY_X:      cfg_next.gravity_x      = cfg_data;
                REG_GRAVITY_Y:      cfg_next.gravity_y      = cfg_data;
                REG_BODY_MASS:      cfg_next.body_mass      = cfg_data[30:0];
                REG_SPEED_LIMIT_X:  cfg_next.speed_limit_x  = cfg_data[30:0];
                REG_SPEED_LIMIT_Y:  cfg_next.speed_limit_y  = cfg_data[30:0];
                REG_FRICTION_FORCE: cfg_next.friction_force = cfg_data[30:0];
                REG_GRAVITY_ENABLE: cfg_next.gravity_enable = cfg_data[0];
                REG_TIME_STEP:      cfg_next.time_step      = cfg_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity_x      <= RST_GRAVITY_X;
            cfg_reg.gravity_y      <= RST_GRAVITY_Y;
            cfg_reg.body_mass      <= RST_BODY_MASS;
            cfg_reg.speed_limit_x  <= RST_SPEED_LIMIT_X;
            cfg_reg.speed_limit_y  <= RST_SPEED_LIMIT_Y;
            cfg_reg.friction_force <= RST_FRICTION_FORCE;
            cfg_reg.gravity_enable <= RST_GRAVITY_ENABLE;
            cfg_reg.time_step      <= RST_TIME_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pbms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    pbms_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .status    (status),
        .func      (s_axis_tuser),
        .force_x   (s_axis_tdata[31:0]),
        .force_y   (s_axis_tdata[63:32]),
        .pos_in_x  (s_axis_tdata[95:64]),
        .pos_in_y  (s_axis_tdata[127:96]),
        .pos_out_x (pos_out_x),
        .pos_out_y (pos_out_y),
        .vel_out_x (vel_out_x),
        .vel_out_y (vel_out_y),
        .grounded  (grounded)
    );

    // Pack the result item
    assign m_axis_tdata = {7'd0, grounded, vel_out_y, vel_out_x, pos_out_y, pos_out_x};

    // Never overwrite a result item that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before taken");

    // Capture happens only on an accepted input item
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |-> (s_axis_tvalid && s_axis_tready))
        else $error("load without accepted item");

    // After an accepted item the input side closes while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while item in work");

    // A result appears only after the output register was loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.out_load))
        else $error("result valid without load");

endmodule
